// ----- rtl/fvn_pkg.sv -----
package fvn_pkg;

  typedef enum logic [1:0] {
    CFG_SEED      = 2'd0,
    CFG_OCTAVES   = 2'd1,
    CFG_BASE_FREQ = 2'd2,
    CFG_PERSIST   = 2'd3
  } cfg_idx_t;

  localparam int MAX_OCTAVES_DEF   = 4;
  localparam int FRACTION_BITS_DEF = 16;

  localparam logic [31:0] SEED_RST      = 32'd1;
  localparam logic [2:0]  OCTAVES_RST   = 3'd4;
  localparam logic [23:0] BASE_FREQ_RST = 24'd58982;
  localparam logic [15:0] PERSIST_RST   = 16'd39322;

  localparam logic [31:0] HASH_MUL_Y = 32'd57;
  localparam int          HASH_SHIFT = 13;
  localparam logic [31:0] HASH_C1    = 32'd15731;
  localparam logic [31:0] HASH_C2    = 32'd789221;
  localparam logic [31:0] HASH_C3    = 32'd1376312589;
  localparam logic [31:0] VAL_ONE    = 32'h4000_0000;
  localparam logic [31:0] OCT_OFFSET = 32'd4096;

  localparam logic [16:0] AMP_ONE    = 17'd65536;
  localparam int          AMP_SHIFT  = 16;
  localparam int          AMP_W      = 17;

  localparam int HASH_LAT = 5;
  localparam int CR_LAT   = 4;
  localparam int OCT_LAT  = 2 + HASH_LAT + 2 * CR_LAT + 1;

  localparam int VAL_W    = 32;
  localparam int ROW_W    = VAL_W + 2;
  localparam int SMOOTH_W = ROW_W + 2;
  localparam int TERM_W   = SMOOTH_W + 2;

  localparam int NV_W       = 21;
  localparam int NV_MAX     = 1048575;
  localparam int NV_MIN     = -1048576;
  localparam int NV_SHIFT   = 15;
  localparam int GRAY_SCALE = 255;
  localparam int GRAY_ONE_SHIFT = 16;

endpackage

// ----- rtl/fvn_hash.sv -----
module fvn_hash
  import fvn_pkg::*;
(
  input  logic                    clk,
  input  logic                    en,
  input  logic [31:0]             x,
  input  logic [31:0]             y,
  input  logic [31:0]             seed,
  output logic signed [VAL_W-1:0] val
);

  logic [31:0] n0;
  logic [31:0] n1_r, n2_r, n3_r, sq_r, a_r, b_r;
  logic signed [VAL_W-1:0] val_r;

  assign n0 = x + y * HASH_MUL_Y + seed;

  always_ff @(posedge clk) begin
    if (en) begin
      n1_r  <= n0 ^ (n0 << HASH_SHIFT);
      sq_r  <= n1_r * n1_r;
      n2_r  <= n1_r;
      a_r   <= sq_r * HASH_C1 + HASH_C2;
      n3_r  <= n2_r;
      b_r   <= n3_r * a_r + HASH_C3;
      val_r <= $signed(VAL_ONE - {1'b0, b_r[30:0]});
    end
  end

  assign val = val_r;

endmodule

// ----- rtl/fvn_cr.sv -----
module fvn_cr
  import fvn_pkg::*;
#(
  parameter int W  = VAL_W,
  parameter int FB = FRACTION_BITS_DEF
) (
  input  logic                  clk,
  input  logic                  en,
  input  logic signed [W-1:0]   p [4],
  input  logic [FB-1:0]         t,
  output logic signed [W+1:0]   q
);

  localparam int KW = W + 4;
  localparam int HW = W + 5;
  localparam int PW = HW + FB + 1;

  logic signed [KW-1:0] e0, e1, e2, e3, k3, k2, k1, k0;
  logic signed [KW-1:0] k2_r, k1_r, k0_r, k1_r2, k0_r2, k0_r3;
  logic [FB-1:0]        t1_r, t2_r;
  logic signed [PW-1:0] p1_r, p2_r, p3_r;
  logic signed [HW-1:0] h2, h3, h4;
  logic signed [W+1:0]  q_r;

  assign e0 = KW'(p[0]);
  assign e1 = KW'(p[1]);
  assign e2 = KW'(p[2]);
  assign e3 = KW'(p[3]);
  assign k3 = -e0 + 3 * e1 - 3 * e2 + e3;
  assign k2 = 2 * e0 - 5 * e1 + 4 * e2 - e3;
  assign k1 = e2 - e0;
  assign k0 = 2 * e1;

  assign h2 = HW'(p1_r >>> FB) + HW'(k2_r);
  assign h3 = HW'(p2_r >>> FB) + HW'(k1_r2);
  assign h4 = HW'(p3_r >>> FB) + HW'(k0_r3);

  always_ff @(posedge clk) begin
    if (en) begin
      p1_r  <= PW'(k3) * PW'($signed({1'b0, t}));
      k2_r  <= k2;
      k1_r  <= k1;
      k0_r  <= k0;
      t1_r  <= t;
      p2_r  <= PW'(h2) * PW'($signed({1'b0, t1_r}));
      k1_r2 <= k1_r;
      k0_r2 <= k0_r;
      t2_r  <= t1_r;
      p3_r  <= PW'(h3) * PW'($signed({1'b0, t2_r}));
      k0_r3 <= k0_r2;
      q_r   <= (W+2)'(h4 >>> 1);
    end
  end

  assign q = q_r;

endmodule

// ----- rtl/fvn_octave.sv -----
module fvn_octave
  import fvn_pkg::*;
#(
  parameter int OCT = 0,
  parameter int FB  = FRACTION_BITS_DEF
) (
  input  logic                     clk,
  input  logic                     en,
  input  logic [31:0]              coord_x,
  input  logic [31:0]              coord_y,
  input  logic [23:0]              base_freq,
  input  logic [31:0]              seed,
  input  logic [AMP_W-1:0]         amp,
  output logic signed [TERM_W-1:0] term
);

  localparam int FYD = HASH_LAT + CR_LAT;
  localparam int SP  = SMOOTH_W + AMP_W + 1;

  logic [55:0]   px_r, py_r;
  logic [63:0]   sx, sy;
  logic [31:0]   ix_r, iy_r;
  logic [FB-1:0] fx_r, fy_r;
  logic [FB-1:0] fxd_r [HASH_LAT];
  logic [FB-1:0] fyd_r [FYD];
  logic signed [VAL_W-1:0]    hv   [4][4];
  logic signed [ROW_W-1:0]    rows [4];
  logic signed [SMOOTH_W-1:0] smooth;
  logic signed [TERM_W-1:0]   term_r;

  // shift into octave scale, wrapping at 64 bits
  assign sx = 64'(px_r) << OCT;
  assign sy = 64'(py_r) << OCT;

  always_ff @(posedge clk) begin
    if (en) begin
      px_r <= 56'(coord_x) * 56'(base_freq);
      py_r <= 56'(coord_y) * 56'(base_freq);
      ix_r <= sx[63:32] + 32'(OCT) * OCT_OFFSET;
      iy_r <= sy[63:32] + 32'(OCT) * OCT_OFFSET;
      fx_r <= sx[31 -: FB];
      fy_r <= sy[31 -: FB];
      fxd_r[0] <= fx_r;
      for (int i = 1; i < HASH_LAT; i++) fxd_r[i] <= fxd_r[i-1];
      fyd_r[0] <= fy_r;
      for (int i = 1; i < FYD; i++) fyd_r[i] <= fyd_r[i-1];
      term_r <= TERM_W'((SP'(smooth) * SP'($signed({1'b0, amp}))) >>> AMP_SHIFT);
    end
  end

  for (genvar r = 0; r < 4; r++) begin : g_row
    for (genvar c = 0; c < 4; c++) begin : g_col
      fvn_hash u_hash (
        .clk  (clk),
        .en   (en),
        .x    (ix_r + 32'(c) - 32'd1),
        .y    (iy_r + 32'(r) - 32'd1),
        .seed (seed),
        .val  (hv[r][c])
      );
    end
    fvn_cr #(.W(VAL_W), .FB(FB)) u_cr_row (
      .clk (clk),
      .en  (en),
      .p   (hv[r]),
      .t   (fxd_r[HASH_LAT-1]),
      .q   (rows[r])
    );
  end

  fvn_cr #(.W(ROW_W), .FB(FB)) u_cr_col (
    .clk (clk),
    .en  (en),
    .p   (rows),
    .t   (fyd_r[FYD-1]),
    .q   (smooth)
  );

  assign term = term_r;

endmodule

// ----- rtl/fractal_value_noise_cubic_unit.sv -----
// Pipeline: 18 register stages (the first loads at the edge that takes an item):
//   coordinate scaling (2),
//   lattice hash (5), row and column interpolation (4 + 4), octave weighting (1),
//   octave sum (1) and the output register (1).
// Throughput: one item per cycle; all octaves run side by side, and a stall
//   at the output freezes every stage at once.
module fractal_value_noise_cubic_unit
  import fvn_pkg::*;
#(
  parameter int MAX_OCTAVES   = MAX_OCTAVES_DEF,
  parameter int FRACTION_BITS = FRACTION_BITS_DEF
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_valid,
  output logic                   in_ready,
  input  logic [31:0]            in_coord_x,
  input  logic [31:0]            in_coord_y,
  output logic                   out_valid,
  input  logic                   out_ready,
  output logic signed [NV_W-1:0] out_noise_value,
  output logic [7:0]             out_gray_level,
  input  logic                   cfg_we,
  input  logic [1:0]             cfg_idx,
  input  logic [31:0]            cfg_wdata
);

  // Reset: synchronous, active low; clears the valid bits and loads the register defaults.

  localparam int SW    = TERM_W + $clog2(MAX_OCTAVES) + 1;
  localparam int LAT_V = OCT_LAT + 1;

  logic        en;
  logic [31:0] seed_r;
  logic [2:0]  octaves_r;
  logic [23:0] base_freq_r;
  logic [15:0] persist_r;

  logic [AMP_W-1:0]         amp  [MAX_OCTAVES];
  logic signed [TERM_W-1:0] term [MAX_OCTAVES];
  logic [LAT_V-1:0]         v_r;

  logic signed [SW-1:0]     sum_nxt, sum_r, nv_full, nv_shift;
  logic signed [NV_W-1:0]   nv_sat;
  logic [28:0]              gray_prod;
  logic [7:0]               gray;
  logic                     out_valid_r;
  logic signed [NV_W-1:0]   nv_r;
  logic [7:0]               gray_r;

  // Advance the whole pipeline whenever the output register can move.
  assign en       = !out_valid_r || out_ready;
  assign in_ready = en;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      seed_r      <= SEED_RST;
      octaves_r   <= OCTAVES_RST;
      base_freq_r <= BASE_FREQ_RST;
      persist_r   <= PERSIST_RST;
    end else if (cfg_we) begin
      unique case (cfg_idx_t'(cfg_idx))
        CFG_SEED:      seed_r      <= cfg_wdata;
        CFG_OCTAVES:   octaves_r   <= cfg_wdata[2:0];
        CFG_BASE_FREQ: base_freq_r <= cfg_wdata[23:0];
        CFG_PERSIST:   persist_r   <= cfg_wdata[15:0];
        default:       seed_r      <= seed_r;
      endcase
    end
  end

  // Amplitude per octave depends on configuration only. The chain settles in
  // fewer cycles than an item needs to reach the weighting stage; the user must
  // change configuration only while no item is in flight (the block does not enforce it).
  assign amp[0] = AMP_ONE;
  for (genvar i = 1; i < MAX_OCTAVES; i++) begin : g_amp
    logic [AMP_W-1:0] amp_r;
    logic [AMP_W+15:0] amp_prod;
    assign amp_prod = (AMP_W+16)'(amp[i-1]) * (AMP_W+16)'(persist_r);
    always_ff @(posedge clk) begin
      amp_r <= AMP_W'(amp_prod >> AMP_SHIFT);
    end
    assign amp[i] = amp_r;
  end

  for (genvar i = 0; i < MAX_OCTAVES; i++) begin : g_oct
    fvn_octave #(.OCT(i), .FB(FRACTION_BITS)) u_oct (
      .clk       (clk),
      .en        (en),
      .coord_x   (in_coord_x),
      .coord_y   (in_coord_y),
      .base_freq (base_freq_r),
      .seed      (seed_r),
      .amp       (amp[i]),
      .term      (term[i])
    );
  end

  // Drop octaves at or above the programmed count; counts above the
  // instantiated octaves saturate naturally.
  always_comb begin
    sum_nxt = '0;
    for (int i = 0; i < MAX_OCTAVES; i++) begin
      if (32'(i) < 32'(octaves_r)) sum_nxt = sum_nxt + SW'(term[i]);
    end
  end

  // Map (sum + 1) / 2 to Q4.16, saturate, then scale to a gray level.
  always_comb begin
    nv_full  = sum_r + SW'($signed({1'b0, VAL_ONE}));
    nv_shift = nv_full >>> NV_SHIFT;
    if (nv_shift > SW'(NV_MAX))      nv_sat = NV_W'(NV_MAX);
    else if (nv_shift < SW'(NV_MIN)) nv_sat = NV_W'(NV_MIN);
    else                             nv_sat = NV_W'(nv_shift);
    gray_prod = 29'(nv_sat[NV_W-2:0]) * 29'(GRAY_SCALE);
    if (nv_sat <= 0)                          gray = 8'd0;
    else if (gray_prod[28:GRAY_ONE_SHIFT] > 13'(GRAY_SCALE)) gray = 8'(GRAY_SCALE);
    else                                      gray = gray_prod[GRAY_ONE_SHIFT +: 8];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r         <= '0;
      out_valid_r <= 1'b0;
    end else if (en) begin
      v_r         <= {v_r[LAT_V-2:0], in_valid};
      out_valid_r <= v_r[LAT_V-1];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sum_r  <= sum_nxt;
      nv_r   <= nv_sat;
      gray_r <= gray;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_noise_value = nv_r;
  assign out_gray_level  = gray_r;

`ifndef SYNTHESIS
  a_accept_tracked: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> v_r[0])
    else $error("accepted item not tracked");
  a_stall_holds: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ready |=> $stable(v_r))
    else $error("pipeline moved during stall");
  a_gray_low: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_noise_value <= 0) |-> out_gray_level == 8'd0)
    else $error("gray not zero for non-positive value");
  a_gray_high: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_noise_value >= 65536) |-> out_gray_level == 8'd255)
    else $error("gray not full scale");
`endif

endmodule

// ----- sim/tb_fractal_value_noise_cubic_unit.sv -----
`timescale 1ns / 100ps

module tb_fractal_value_noise_cubic_unit;
  import fvn_pkg::*;

  localparam int DRAIN_CYCLES = 24;   // more than the pipeline depth, with margin
  localparam int STALL_LIMIT  = 5000; // cycles with no item moving on either side

  typedef struct packed {
    logic signed [NV_W-1:0] noise_value;
    logic [7:0]             gray_level;
  } noise_result_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic [31:0] in_coord_x = '0;
  logic [31:0] in_coord_y = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic signed [NV_W-1:0] out_noise_value;
  logic [7:0] out_gray_level;
  logic cfg_we = 1'b0;
  logic [1:0] cfg_idx = '0;
  logic [31:0] cfg_wdata = '0;

  // Shadow copy of the configuration registers, updated when a write is issued.
  logic [31:0] shadow_seed;
  logic [2:0]  shadow_octaves;
  logic [23:0] shadow_freq;
  logic [15:0] shadow_persist;

  noise_result_t expected_noise_q[$];
  int error_count = 0;
  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  int quiet_cycles = 0;

  fractal_value_noise_cubic_unit u_dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready),
    .in_coord_x(in_coord_x), .in_coord_y(in_coord_y),
    .out_valid(out_valid), .out_ready(out_ready),
    .out_noise_value(out_noise_value), .out_gray_level(out_gray_level),
    .cfg_we(cfg_we), .cfg_idx(cfg_idx), .cfg_wdata(cfg_wdata)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // Noise predictor
  // ---------------------------------------------------------------------------

  // Lattice hash: wrapping 32-bit integer hash, returned as Q2.30 (1 - m/2^30).
  function automatic longint lattice_hash(logic [31:0] lx, logic [31:0] ly);
    logic [31:0] n;
    logic [31:0] m;
    n = lx + ly * HASH_MUL_Y + shadow_seed;
    n = (n << HASH_SHIFT) ^ n;
    m = (n * (n * n * HASH_C1 + HASH_C2) + HASH_C3) & 32'h7fff_ffff;
    return longint'(VAL_ONE) - longint'(m);
  endfunction

  // Catmull-Rom on doubled integer coefficients, Horner form; every product
  // with t is floored by the fraction width, then the result is halved (floored).
  function automatic longint spline_eval(longint p0, longint p1, longint p2, longint p3,
                                         logic [15:0] t);
    longint k3, k2, k1, k0, h, tt;
    k3 = -p0 + 3 * p1 - 3 * p2 + p3;
    k2 = 2 * p0 - 5 * p1 + 4 * p2 - p3;
    k1 = p2 - p0;
    k0 = 2 * p1;
    tt = longint'({48'd0, t});
    h = ((k3 * tt) >>> FRACTION_BITS_DEF) + k2;
    h = ((h * tt) >>> FRACTION_BITS_DEF) + k1;
    h = ((h * tt) >>> FRACTION_BITS_DEF) + k0;
    return h >>> 1;
  endfunction

  function automatic noise_result_t predict_noise(logic [31:0] cx, logic [31:0] cy);
    logic [63:0] prod_x, prod_y;
    logic [31:0] lat_x, lat_y;
    logic [15:0] frac_x, frac_y;
    longint row_val[4];
    longint corner[4];
    longint smooth, sum, nv, gray, amp;
    int octaves;
    noise_result_t res;
    octaves = (shadow_octaves > MAX_OCTAVES_DEF) ? MAX_OCTAVES_DEF : int'(shadow_octaves);
    amp = 65536;
    sum = 0;
    for (int oct = 0; oct < octaves; oct++) begin
      prod_x = (64'(cx) * 64'(shadow_freq)) << oct;
      prod_y = (64'(cy) * 64'(shadow_freq)) << oct;
      lat_x = prod_x[63:32] + 32'(oct) * OCT_OFFSET;
      lat_y = prod_y[63:32] + 32'(oct) * OCT_OFFSET;
      frac_x = prod_x[31:16];
      frac_y = prod_y[31:16];
      for (int r = 0; r < 4; r++) begin
        for (int c = 0; c < 4; c++)
          corner[c] = lattice_hash(lat_x + 32'(c) - 32'd1, lat_y + 32'(r) - 32'd1);
        row_val[r] = spline_eval(corner[0], corner[1], corner[2], corner[3], frac_x);
      end
      smooth = spline_eval(row_val[0], row_val[1], row_val[2], row_val[3], frac_y);
      sum += (smooth * amp) >>> AMP_SHIFT;
      amp = (amp * longint'(shadow_persist)) >> AMP_SHIFT;
    end
    nv = (sum + 64'sd1073741824) >>> NV_SHIFT;
    if (nv > NV_MAX) nv = NV_MAX;
    if (nv < NV_MIN) nv = NV_MIN;
    if (nv <= 0) begin
      gray = 0;
    end else begin
      gray = (nv * GRAY_SCALE) >> GRAY_ONE_SHIFT;
      if (gray > 255) gray = 255;
    end
    res.noise_value = nv[NV_W-1:0];
    res.gray_level = gray[7:0];
    return res;
  endfunction

  // ---------------------------------------------------------------------------
  // Monitors: record each accepted item, check each result, watch for hangs
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_valid && in_ready)
        expected_noise_q.push_back(predict_noise(in_coord_x, in_coord_y));
      if (out_valid && out_ready) begin
        if (expected_noise_q.size() == 0) begin
          $error("unexpected result: noise_value %0d gray_level %0d",
                 out_noise_value, out_gray_level);
          error_count++;
        end else begin
          noise_result_t exp_res;
          exp_res = expected_noise_q.pop_front();
          if (out_noise_value !== exp_res.noise_value) begin
            $error("noise_value: expected %0d, got %0d", exp_res.noise_value, out_noise_value);
            error_count++;
          end
          if (out_gray_level !== exp_res.gray_level) begin
            $error("gray_level: expected %0d, got %0d", exp_res.gray_level, out_gray_level);
            error_count++;
          end
        end
      end
      // Count only cycles in which nothing moves on either channel.
      if ((in_valid && in_ready) || (out_valid && out_ready))
        quiet_cycles <= 0;
      else
        quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= STALL_LIMIT) begin
        $display("Some tests failed");
        $finish;
      end
    end
  end

  // Receiver: stall at random at the current rate.
  always @(posedge clk) begin
    out_ready <= ($urandom_range(99) >= recv_idle_pct);
  end

  // ---------------------------------------------------------------------------
  // Shared tasks
  // ---------------------------------------------------------------------------

  // Issue a register write; call only while the pipeline is empty.
  task automatic write_reg(cfg_idx_t idx, logic [31:0] value);
    cfg_we <= 1'b1;
    cfg_idx <= idx;
    cfg_wdata <= value;
    case (idx)
      CFG_SEED:      shadow_seed = value;
      CFG_OCTAVES:   shadow_octaves = value[2:0];
      CFG_BASE_FREQ: shadow_freq = value[23:0];
      CFG_PERSIST:   shadow_persist = value[15:0];
      default: ;
    endcase
    @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  task automatic set_config(logic [31:0] seed_v, logic [2:0] oct_v,
                            logic [23:0] freq_v, logic [15:0] pers_v);
    write_reg(CFG_SEED, seed_v);
    write_reg(CFG_OCTAVES, {29'd0, oct_v});
    write_reg(CFG_BASE_FREQ, {8'd0, freq_v});
    write_reg(CFG_PERSIST, {16'd0, pers_v});
  endtask

  // Send one coordinate item; returns at the edge that accepts it, valid still high.
  task automatic send_coord(logic [31:0] x, logic [31:0] y);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_coord_x <= x;
    in_coord_y <= y;
    @(negedge clk);
    while (!in_ready) @(negedge clk);
    @(posedge clk);
  endtask

  // Drop valid, wait for every expected result, then let the pipeline empty.
  task automatic drain_pipeline();
    in_valid <= 1'b0;
    @(posedge clk);
    while (expected_noise_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  function automatic logic [31:0] rand_coord();
    case ($urandom_range(3))
      0: return {16'd0, 16'($urandom)};       // small, upper 16 bits zero
      1: return {8'd0, 24'($urandom)};
      default: return $urandom;
    endcase
  endfunction

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // Field extremes and lattice wrap under the reset configuration.
  task automatic test_reset_defaults();
    send_coord(32'h0, 32'h0);
    send_coord(32'hffff_ffff, 32'hffff_ffff);
    send_coord(32'hffff_ffff, 32'h0);
    send_coord(32'h0, 32'hffff_ffff);
    send_coord(32'h0001_8000, 32'h0002_c000);
    send_coord(32'haaaa_aaaa, 32'h5555_5555);
    drain_pipeline();
  endtask

  // Octave count zero, saturation above the maximum, and extreme registers.
  task automatic test_register_extremes();
    set_config(32'h0, 3'd0, 24'd58982, 16'd39322);  // no octaves: fixed mid value
    send_coord(32'h1234_5678, 32'h9abc_def0);
    send_coord(32'hffff_ffff, 32'h0);
    drain_pipeline();
    for (int oc = 5; oc <= 7; oc++) begin          // count saturates
      set_config(32'hffff_ffff, 3'(oc), 24'hff_ffff, 16'hffff);
      send_coord(32'hffff_ffff, 32'hffff_ffff);
      send_coord(32'h0000_0001, 32'h8000_0000);
      drain_pipeline();
    end
    set_config(32'h8000_0000, 3'd4, 24'd0, 16'd0);  // zero frequency and persistence
    send_coord(32'hdead_beef, 32'h0bad_f00d);
    drain_pipeline();
    set_config(32'h7fff_ffff, 3'd1, 24'hff_ffff, 16'hffff);
    send_coord(32'hffff_ffff, 32'hffff_ffff);
    send_coord(32'h0000_ffff, 32'hffff_0000);
    drain_pipeline();
    // Full persistence with all octaves aims for overshoot on both sides.
    set_config(32'd1, 3'd4, 24'h01_0000, 16'hffff);
    for (int k = 0; k < 6; k++) send_coord($urandom, $urandom);
    drain_pipeline();
  endtask

  // Random coordinates in chunks, with a fresh configuration between chunks.
  task automatic test_random_stream(int items);
    for (int chunk = 0; chunk < 5; chunk++) begin
      set_config($urandom, 3'($urandom_range(7)),
                 ($urandom_range(3) == 0) ? 24'($urandom) : 24'($urandom_range(262143)),
                 16'($urandom));
      for (int k = 0; k < items / 5; k++) send_coord(rand_coord(), rand_coord());
      drain_pipeline();
    end
  endtask

  initial begin
    shadow_seed = SEED_RST;
    shadow_octaves = OCTAVES_RST;
    shadow_freq = BASE_FREQ_RST;
    shadow_persist = PERSIST_RST;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    send_idle_pct = 18;
    recv_idle_pct = 75;
    test_reset_defaults();
    test_register_extremes();
    test_random_stream(330);

    send_idle_pct = 75;
    recv_idle_pct = 18;
    test_random_stream(330);

    send_idle_pct = 0;
    recv_idle_pct = 0;
    test_random_stream(340);

    if (error_count == 0)
      $display("All tests passed");
    else
      $display("Some tests failed");
    $finish;
  end

endmodule
